>>> hw/rtl/kto_pkg.sv
// Package for the k-way time-ordered merge.
// Holds field widths, operation codes, reset values and the shared word types.
// No dependencies.
package kto_pkg;

    // Defaults for the top-level parameters.
    localparam int STREAMS_DEF   = 8;
    localparam int TIME_BITS_DEF = 32;

    // Fixed field widths of the input and output words.
    localparam int OP_W      = 1;
    localparam int SRC_W     = 3;
    localparam int PORT_T_W  = 32;
    localparam int ID_W      = 32;
    localparam int PROC_W    = 16;
    localparam int TAG_W     = 32;
    localparam int ACTIVE_W  = 4;

    // Reset value of the active stream count.
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    // Operation codes carried by the op field.
    localparam logic [OP_W-1:0] OP_HIT = 1'b0;
    localparam logic [OP_W-1:0] OP_FIN = 1'b1;

    // Hit fields that travel with a head but take no part in ordering.
    typedef struct packed {
        logic [ID_W-1:0]   track;
        logic [ID_W-1:0]   particle;
        logic [PROC_W-1:0] process;
        logic [TAG_W-1:0]  tag;
    } hit_data_t;

    // Update broadcast from the top level to every cell, already gated by acceptance.
    typedef struct packed {
        logic hit;
        logic fin;
    } upd_t;

endpackage

>>> hw/rtl/kto_cell.sv
// One head cell of the merge: holds one stream's head hit, its flags and its row of
// pairwise order bits. Depends on kto_pkg.
module kto_cell
    import kto_pkg::*;
#(
    parameter int STREAMS   = STREAMS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int IDX       = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  upd_t                 upd,
    input  logic                 sel,
    input  logic [SRC_W-1:0]     stream,
    input  logic [TIME_BITS-1:0] in_time,
    input  hit_data_t            in_data,
    input  logic                 active,
    input  logic [STREAMS-1:0]   new_lt_all,
    input  logic [STREAMS-1:0]   ld_all,
    input  logic [STREAMS-1:0]   valid_all,
    input  logic                 rdy_in,
    input  logic                 clear,
    output logic                 new_lt,
    output logic                 load,
    output logic                 v_upd,
    output logic                 rdy_out,
    output logic                 win,
    output logic [TIME_BITS-1:0] win_time,
    output hit_data_t            win_data
);

    localparam int CMP_W = (SRC_W > 7) ? SRC_W : 7;
    localparam logic [STREAMS-1:0] SELF_BIT = STREAMS'(1) << IDX;

    logic                 valid_reg, valid_next;
    logic                 done_reg, done_next;
    logic [STREAMS-1:0]   row_reg, row_next;
    logic [TIME_BITS-1:0] time_reg;
    hit_data_t            data_reg;
    logic                 done_upd;
    logic                 idx_above;

    // A new head is taken only when this stream has neither a head nor a finish mark.
    assign load     = upd.hit & sel & ~valid_reg & ~done_reg;
    assign v_upd    = valid_reg | load;
    assign done_upd = done_reg | (upd.fin & sel);

    // Does the incoming hit order before the head held here? Ties go to the lower index.
    assign idx_above = CMP_W'(stream) < CMP_W'(IDX);
    assign new_lt    = (in_time < time_reg) | ((in_time == time_reg) & idx_above);

    // The readiness chain passes along the row of cells.
    assign rdy_out = rdy_in & (~active | v_upd | done_upd);

    // Order row: on own load take the broadcast compares, on another load the inverse.
    always_comb
    begin
        if (load)
        begin
            row_next = new_lt_all;
        end
        else
        begin
            row_next = (ld_all & {STREAMS{~new_lt}}) | (row_reg & ~ld_all);
        end
    end

    // This head wins when it beats every other valid head.
    assign win = v_upd & active & (&(row_next | ~valid_all | SELF_BIT));

    assign win_time = win ? (load ? in_time : time_reg) : '0;
    assign win_data = win ? (load ? in_data : data_reg) : '0;

    assign valid_next = v_upd & ~clear;
    assign done_next  = done_upd;

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Head payload and order row; only read while the head is valid.
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        if (load)
        begin
            time_reg <= in_time;
            data_reg <= in_data;
        end
    end

endmodule

>>> hw/rtl/kway_time_ordered_merge_top.sv
// Top level of the k-way time-ordered merge: row of head cells, configuration
// register and output register. Depends on kto_pkg and kto_cell.
//
//   Channel  Handshake            Word
//   cfg      cfg_valid/cfg_ready  cfg_data (active stream count)
//   in       in_valid/in_ready    op, stream, start_time, track_id, particle_num,
//                                 process_key, payload_tag
//   out      out_valid/out_ready  source_stream, out_time, out_track, out_particle,
//                                 out_process, out_tag
//
// One input word is taken every cycle while in_ready is high; its result, if any, sits
// in the output register from the next cycle. The rate rests on the per-cell time compare
// against the incoming hit and each cell's order bits, so selection is one AND per cell.
// Reset clears head and finish flags and sets the active count to eight; no clearing pass.
// in_ready drops only while the output register is full and out_ready is low.
module kway_time_ordered_merge_top
    import kto_pkg::*;
#(
    parameter int STREAMS   = STREAMS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ACTIVE_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     op,
    input  logic [SRC_W-1:0]    stream,
    input  logic [PORT_T_W-1:0] start_time,
    input  logic [ID_W-1:0]     track_id,
    input  logic [ID_W-1:0]     particle_num,
    input  logic [PROC_W-1:0]   process_key,
    input  logic [TAG_W-1:0]    payload_tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SRC_W-1:0]    source_stream,
    output logic [PORT_T_W-1:0] out_time,
    output logic [ID_W-1:0]     out_track,
    output logic [ID_W-1:0]     out_particle,
    output logic [PROC_W-1:0]   out_process,
    output logic [TAG_W-1:0]    out_tag
);

    localparam int IW     = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int IDXW   = (IW > SRC_W) ? IW : SRC_W;
    localparam int WIDE_T = (TIME_BITS > PORT_T_W) ? TIME_BITS : PORT_T_W;
    localparam int CMP_W  = (IDXW > 7) ? IDXW : 7;

    logic [ACTIVE_W-1:0]  active_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [SRC_W-1:0]     src_reg;
    logic [TIME_BITS-1:0] time_reg;
    hit_data_t            data_reg;

    logic                 acc;
    upd_t                 upd;
    logic [WIDE_T-1:0]    tin_wide;
    logic [TIME_BITS-1:0] in_time;
    hit_data_t            in_data;
    logic [STREAMS-1:0]   active;
    logic [STREAMS-1:0]   sel;
    logic [STREAMS-1:0]   new_lt_all;
    logic [STREAMS-1:0]   ld_all;
    logic [STREAMS-1:0]   v_upd;
    logic [STREAMS-1:0]   valid_all;
    logic [STREAMS-1:0]   win;
    logic [STREAMS-1:0]   clear;
    logic [STREAMS:0]     rdy_chain;
    logic [TIME_BITS-1:0] cell_time [STREAMS];
    hit_data_t            cell_data [STREAMS];
    logic                 emit;
    logic [IDXW-1:0]      win_idx;
    logic [TIME_BITS-1:0] win_time;
    hit_data_t            win_data;
    logic [WIDE_T-1:0]    tout_wide;

    // Configuration is accepted at any time.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_valid)
        begin
            active_reg <= cfg_data;
        end
    end

    // Input word handling: a word is taken whenever the output register can move.
    assign in_ready = ~out_valid_reg | out_ready;
    assign acc      = in_valid & in_ready;
    assign upd.hit  = acc & (op == OP_HIT);
    assign upd.fin  = acc & (op == OP_FIN);

    assign tin_wide = WIDE_T'(start_time);
    assign in_time  = tin_wide[TIME_BITS-1:0];
    assign in_data  = '{track: track_id, particle: particle_num, process: process_key,
                        tag: payload_tag};

    // Active mask: a count of zero still enables stream zero.
    always_comb
    begin
        for (int i = 0; i < STREAMS; i++)
        begin
            active[i] = (i == 0) || (CMP_W'(active_reg) > CMP_W'(i));
            sel[i]    = active[i] && (CMP_W'(stream) == CMP_W'(i));
        end
    end

    assign rdy_chain[0] = 1'b1;
    assign valid_all    = v_upd & active;

    // The row of head cells.
    for (genvar g = 0; g < STREAMS; g++)
    begin : g_cell
        kto_cell #(
            .STREAMS   (STREAMS),
            .TIME_BITS (TIME_BITS),
            .IDX       (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .upd        (upd),
            .sel        (sel[g]),
            .stream     (stream),
            .in_time    (in_time),
            .in_data    (in_data),
            .active     (active[g]),
            .new_lt_all (new_lt_all),
            .ld_all     (ld_all),
            .valid_all  (valid_all),
            .rdy_in     (rdy_chain[g]),
            .clear      (clear[g]),
            .new_lt     (new_lt_all[g]),
            .load       (ld_all[g]),
            .v_upd      (v_upd[g]),
            .rdy_out    (rdy_chain[g+1]),
            .win        (win[g]),
            .win_time   (cell_time[g]),
            .win_data   (cell_data[g])
        );
    end

    // Emit on acceptance if each active stream has a head or is done, and a head exists.
    assign emit  = acc & rdy_chain[STREAMS] & (|valid_all);
    assign clear = {STREAMS{emit}} & win;

    // Gather the winning cell's word; at most one cell gates its word through.
    always_comb
    begin
        win_idx  = '0;
        win_time = '0;
        win_data = '0;
        for (int i = 0; i < STREAMS; i++)
        begin
            if (win[i])
            begin
                win_idx = IDXW'(i);
            end
            win_time = win_time | cell_time[i];
            win_data = win_data | cell_data[i];
        end
    end

    // Output register.
    assign out_valid_next = emit | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            src_reg  <= win_idx[SRC_W-1:0];
            time_reg <= win_time;
            data_reg <= win_data;
        end
    end

    assign tout_wide     = WIDE_T'(time_reg);
    assign out_valid     = out_valid_reg;
    assign source_stream = src_reg;
    assign out_time      = tout_wide[PORT_T_W-1:0];
    assign out_track     = data_reg.track;
    assign out_particle  = data_reg.particle;
    assign out_process   = data_reg.process;
    assign out_tag       = data_reg.tag;

endmodule
